// ----- src/lj_pkg.sv -----
// ----------------------------------------------------------------------------
// lj_pkg
// Types and constants shared by the Lennard-Jones pair kernel.
// ----------------------------------------------------------------------------
package lj_pkg;

   localparam int R_W    = 48;   // r2, sigma^2: unsigned Q8.40
   localparam int E_W    = 24;   // epsilon: unsigned Q8.16
   localparam int Z_W    = 64;   // z: unsigned Q11.53
   localparam int RES_W  = 64;   // results: signed Q47.16
   localparam int WIDE_W = 128;  // full 64x64 products
   localparam int Y_W    = 86;   // force quotient bits kept before saturation

   localparam logic [RES_W-1:0] NEG_MAX  = 64'h8000_0000_0000_0000;
   localparam logic [RES_W-1:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [Z_W-1:0]   ONE_Q31  = 64'h0000_0000_8000_0000;
   localparam logic [Z_W-1:0]   HALF_Q31 = 64'h0000_0000_4000_0000;

   // register indexes of the csr port
   localparam logic [1:0] CSR_WELL_DEPTH    = 2'd0;
   localparam logic [1:0] CSR_SIGMA_SQUARED = 2'd1;

   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_ZERO,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     in_cut;
   } tag_type;

   typedef struct packed {
      tag_type        tag;
      logic [R_W-1:0] r2;
   } base_type;

   typedef struct packed {
      base_type       base;
      logic [Z_W-1:0] z;
   } zz_side_type;

   typedef struct packed {
      base_type base;
      logic     neg_pot;
   } uu_side_type;

   typedef struct packed {
      base_type          base;
      logic              neg_pot;
      logic              neg_frc;
      logic [WIDE_W-1:0] t_frc;
   } pe_side_type;

   typedef struct packed {
      tag_type          tag;
      logic             neg_frc;
      logic             big;
      logic [RES_W-1:0] pot;
      logic             pot_sat;
   } dv_side_type;

   typedef struct packed {
      logic [RES_W-1:0] force_scalar;
      logic [RES_W-1:0] pair_potential;
      logic             inside_cutoff;
      logic             saturated;
   } res_type;

endpackage

// ----- src/lj_if.sv -----
// ----------------------------------------------------------------------------
// lj_req_if / lj_rsp_if
// Valid/ready channels of the pair kernel: distance in, force and energy out.
// ----------------------------------------------------------------------------
interface lj_req_if import lj_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [R_W-1:0] dist_squared;

   modport source (output valid, output dist_squared, input ready);
   modport sink   (input valid, input dist_squared, output ready);
endinterface

interface lj_rsp_if import lj_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] force_scalar;
   logic signed [RES_W-1:0] pair_potential;
   logic                    inside_cutoff;
   logic                    saturated;

   modport source (output valid, output force_scalar, output pair_potential,
                   output inside_cutoff, output saturated, input ready);
   modport sink   (input valid, input force_scalar, input pair_potential,
                   input inside_cutoff, input saturated, output ready);
endinterface

// ----- src/lj_div.sv -----
// ----------------------------------------------------------------------------
// lj_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; the low bits shift in MSB first.
// ----------------------------------------------------------------------------
module lj_div #(
   parameter int QW = 64,
   parameter int DW = 48,
   parameter int SW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_bits,
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [DW-1:0] out_div,
   output logic [SW-1:0] out_side
);

   logic          v_ff   [QW];
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] x_ff   [QW];   // remaining dividend bits, quotient fills from the LSB
   logic [DW-1:0] d_ff   [QW];
   logic [SW-1:0] s_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          v_src;
      logic [DW-1:0] rem_src;
      logic [QW-1:0] x_src;
      logic [DW-1:0] d_src;
      logic [SW-1:0] s_src;
      logic [DW:0]   cur;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] x_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_rem;
         assign x_src   = in_bits;
         assign d_src   = in_div;
         assign s_src   = in_side;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign d_src   = d_ff[k-1];
         assign s_src   = s_ff[k-1];
      end

      assign cur    = {rem_src, x_src[QW-1]};
      assign diff   = cur - {1'b0, d_src};
      assign ge     = cur >= {1'b0, d_src};
      assign rem_in = ge ? diff[DW-1:0] : cur[DW-1:0];
      assign x_in   = {x_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            x_ff[k]   <= x_in;
            d_ff[k]   <= d_src;
            s_ff[k]   <= s_src;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quo   = x_ff[QW-1];
   assign out_div   = d_ff[QW-1];
   assign out_side  = s_ff[QW-1];

endmodule

// ----- src/lj_mul.sv -----
// ----------------------------------------------------------------------------
// lj_mul
// Two-stage unsigned multiplier: 32x32 partial products, then their sum.
// ----------------------------------------------------------------------------
module lj_mul #(
   parameter int AW = 64,
   parameter int BW = 64,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [AW-1:0]    in_a,
   input  logic [BW-1:0]    in_b,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [AW+BW-1:0] out_prod,
   output logic [SW-1:0]    out_side
);

   localparam int NA = (AW + 31) / 32;
   localparam int NB = (BW + 31) / 32;
   localparam int PW = AW + BW;

   logic [NA*32-1:0] a_pad;
   logic [NB*32-1:0] b_pad;
   logic [63:0]      pp_ff [NA][NB];
   logic             v1_ff, v2_ff;
   logic [SW-1:0]    side1_ff, side2_ff;
   logic [PW-1:0]    sum_in, prod_ff;

   assign a_pad = (NA*32)'(in_a);
   assign b_pad = (NB*32)'(in_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
            end
         end
         side1_ff <= in_side;
         prod_ff  <= sum_in;
         side2_ff <= side1_ff;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i][j]) << (32 * (i + j)));
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side2_ff;

endmodule

// ----- src/lennard_jones_pair_force.sv -----
// ----------------------------------------------------------------------------
// lennard_jones_pair_force
// 12-6 Lennard-Jones force coefficient and pair potential for one squared
// pair distance per cycle, fixed point, saturating.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        dist_squared (Q8.40)
//  rsp      out  valid/ready        force_scalar, pair_potential (Q47.16),
//                                   inside_cutoff, saturated
//  csr      in   csr_wr_en          csr_index, csr_wdata
//
//  One item per cycle sustained while rsp.ready stays high.
//  Most of the pipe lies in the two bit-per-stage dividers (64 and 86 stages).
//  reset is synchronous; it empties the pipe and loads eps=1.0, sig2=1e-4.
//  A stall freezes the whole pipe; a skid entry behind the output register
//  lets one more item land, so req.ready is a flop (not skid full).
// ----------------------------------------------------------------------------
module lennard_jones_pair_force import lj_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   lj_req_if.sink         req,
   lj_rsp_if.source       rsp,
   input  logic           csr_wr_en,
   input  logic [1:0]     csr_index,
   input  logic [R_W-1:0] csr_wdata
);

   // ---------------- configuration ----------------
   logic [E_W-1:0] well_depth_ff;
   logic [R_W-1:0] sigma_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         well_depth_ff <= 24'd65536;
         sigma_sq_ff   <= 48'd109951163;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_WELL_DEPTH) begin
            well_depth_ff <= csr_wdata[E_W-1:0];
         end
         if (csr_index == CSR_SIGMA_SQUARED) begin
            sigma_sq_ff <= csr_wdata;
         end
      end
   end

   // Global advance: the pipe moves whenever the skid entry is free.
   logic en;
   logic skid_v_ff;
   assign en        = ~skid_v_ff;
   assign req.ready = en;

   // ---------------- input register ----------------
   logic           in_v_ff;
   logic [R_W-1:0] in_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_r2_ff <= req.dist_squared;
      end
   end

   // Classify: zero distance, z out of Q11.53 range, or normal; flag r2 < 6.25*sig2 as in cutoff.
   logic [R_W+10:0] r2_x2k;
   logic [R_W+4:0]  r2_x4, sig_x25;
   logic            is_zero, is_close;
   tag_type         front_tag;

   assign r2_x2k   = {in_r2_ff, 11'b0};
   assign is_zero  = in_r2_ff == '0;
   assign is_close = {11'b0, sigma_sq_ff} >= r2_x2k;
   assign r2_x4    = {3'b0, in_r2_ff, 2'b0};
   assign sig_x25  = ({5'b0, sigma_sq_ff} << 4) + ({5'b0, sigma_sq_ff} << 3)
                   + {5'b0, sigma_sq_ff};

   always_comb begin
      front_tag.in_cut = r2_x4 < sig_x25;
      if (is_zero) begin
         front_tag.kind = KIND_ZERO;
      end else if (is_close) begin
         front_tag.kind = KIND_CLOSE;
      end else begin
         front_tag.kind = KIND_NORMAL;
      end
   end

   // ---------------- z = sig2 * 2^53 / r2 ----------------
   logic           dz_v;
   logic [Z_W-1:0] dz_z;
   logic [R_W-1:0] dz_r2;
   logic [$bits(tag_type)-1:0] dz_side;
   tag_type        dz_tag;

   lj_div #(.QW(Z_W), .DW(R_W), .SW($bits(tag_type))) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_v_ff),
      .in_rem   ({11'b0, sigma_sq_ff[R_W-1:11]}),
      .in_bits  ({sigma_sq_ff[10:0], 53'b0}),
      .in_div   (in_r2_ff),
      .in_side  (front_tag),
      .out_valid(dz_v),
      .out_quo  (dz_z),
      .out_div  (dz_r2),
      .out_side (dz_side)
   );

   assign dz_tag = dz_side;

   // ---------------- z^2 ----------------
   zz_side_type        za_side_i, za_side_o;
   logic               za_v;
   logic [WIDE_W-1:0]  za_prod;
   logic [$bits(zz_side_type)-1:0] za_side_vec;

   assign za_side_i.base.tag = dz_tag;
   assign za_side_i.base.r2  = dz_r2;
   assign za_side_i.z        = dz_z;

   lj_mul #(.AW(Z_W), .BW(Z_W), .SW($bits(zz_side_type))) u_mul_z2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dz_v),
      .in_a     (dz_z),
      .in_b     (dz_z),
      .in_side  (za_side_i),
      .out_valid(za_v),
      .out_prod (za_prod),
      .out_side (za_side_vec)
   );

   assign za_side_o = za_side_vec;

   // ---------------- u = z^3 (Q33.31) ----------------
   logic              zb_v;
   logic [WIDE_W-1:0] zb_prod;
   logic [$bits(base_type)-1:0] zb_side_vec;
   base_type          zb_base;

   lj_mul #(.AW(Z_W), .BW(Z_W), .SW($bits(base_type))) u_mul_u (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (za_v),
      .in_a     (za_prod[WIDE_W-1:Z_W]),
      .in_b     (za_side_o.z),
      .in_side  (za_side_o.base),
      .out_valid(zb_v),
      .out_prod (zb_prod),
      .out_side (zb_side_vec)
   );

   assign zb_base = zb_side_vec;

   // ---------------- |1-u|, |1/2-u| ----------------
   logic           u_src;
   logic [Z_W-1:0] u_val;
   logic           ud_v_ff;
   logic [Z_W-1:0] u_ff, d_pot_ff, d_frc_ff;
   logic           neg_pot_ff, neg_frc_ff;
   base_type       ud_base_ff;

   assign u_val = zb_prod[WIDE_W-1:Z_W];
   assign u_src = zb_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         ud_v_ff <= 1'b0;
      end else if (en) begin
         ud_v_ff <= u_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff       <= u_val;
         neg_pot_ff <= u_val > ONE_Q31;
         d_pot_ff   <= (u_val > ONE_Q31) ? u_val - ONE_Q31 : ONE_Q31 - u_val;
         neg_frc_ff <= u_val > HALF_Q31;
         d_frc_ff   <= (u_val > HALF_Q31) ? u_val - HALF_Q31 : HALF_Q31 - u_val;
         ud_base_ff <= zb_base;
      end
   end

   // ---------------- u*|1-u| and u*|1/2-u| ----------------
   uu_side_type       cp_side_i, cp_side_o;
   logic              cp_v;
   logic [WIDE_W-1:0] cp_prod, cf_prod;
   logic [$bits(uu_side_type)-1:0] cp_side_vec;
   logic              cf_neg;

   assign cp_side_i.base    = ud_base_ff;
   assign cp_side_i.neg_pot = neg_pot_ff;

   lj_mul #(.AW(Z_W), .BW(Z_W), .SW($bits(uu_side_type))) u_mul_tpot (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ud_v_ff),
      .in_a     (u_ff),
      .in_b     (d_pot_ff),
      .in_side  (cp_side_i),
      .out_valid(cp_v),
      .out_prod (cp_prod),
      .out_side (cp_side_vec)
   );

   assign cp_side_o = cp_side_vec;

   lj_mul #(.AW(Z_W), .BW(Z_W), .SW(1)) u_mul_tfrc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ud_v_ff),
      .in_a     (u_ff),
      .in_b     (d_frc_ff),
      .in_side  (neg_frc_ff),
      .out_valid(),
      .out_prod (cf_prod),
      .out_side (cf_neg)
   );

   // ---------------- eps * u*|1-u| ----------------
   pe_side_type pe_side_i, pe_side_o;
   logic        pe_v;
   logic [WIDE_W+E_W-1:0] pe_prod;
   logic [$bits(pe_side_type)-1:0] pe_side_vec;

   assign pe_side_i.base    = cp_side_o.base;
   assign pe_side_i.neg_pot = cp_side_o.neg_pot;
   assign pe_side_i.neg_frc = cf_neg;
   assign pe_side_i.t_frc   = cf_prod;

   lj_mul #(.AW(WIDE_W), .BW(E_W), .SW($bits(pe_side_type))) u_mul_epot (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (cp_v),
      .in_a     (cp_prod),
      .in_b     (well_depth_ff),
      .in_side  (pe_side_i),
      .out_valid(pe_v),
      .out_prod (pe_prod),
      .out_side (pe_side_vec)
   );

   assign pe_side_o = pe_side_vec;

   // Potential magnitude: 4*eps*t / 2^62 = eps*t / 2^60, then clamp.
   logic [WIDE_W+E_W-61:0] pot_mag;
   logic [RES_W-1:0]       pot_lim;
   logic                   pot_sat;
   logic [RES_W-1:0]       pot_val;
   logic [WIDE_W-Y_W-1:0]  y_rem0;
   dv_side_type            dv_side_i, dv_side_o;

   assign pot_mag = pe_prod[WIDE_W+E_W-1:60];
   assign pot_lim = pe_side_o.neg_pot ? NEG_MAX : POS_MAX;
   assign pot_sat = pot_mag > {28'b0, pot_lim};
   assign pot_val = pot_sat ? pot_lim
                  : (pe_side_o.neg_pot ? -pot_mag[RES_W-1:0] : pot_mag[RES_W-1:0]);

   // Force quotient kept to Y_W bits; a larger one saturates unless eps is zero.
   assign y_rem0 = pe_side_o.t_frc[WIDE_W-1:Y_W];

   assign dv_side_i.tag     = pe_side_o.base.tag;
   assign dv_side_i.neg_frc = pe_side_o.neg_frc;
   assign dv_side_i.big     = {6'b0, y_rem0} >= pe_side_o.base.r2;
   assign dv_side_i.pot     = pot_val;
   assign dv_side_i.pot_sat = pot_sat;

   // ---------------- y = u*|1/2-u| / r2 ----------------
   logic           dy_v;
   logic [Y_W-1:0] dy_y;
   logic [$bits(dv_side_type)-1:0] dy_side_vec;

   lj_div #(.QW(Y_W), .DW(R_W), .SW($bits(dv_side_type))) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pe_v),
      .in_rem   ({6'b0, y_rem0}),
      .in_bits  (pe_side_o.t_frc[Y_W-1:0]),
      .in_div   (pe_side_o.base.r2),
      .in_side  (dv_side_i),
      .out_valid(dy_v),
      .out_quo  (dy_y),
      .out_div  (),
      .out_side (dy_side_vec)
   );

   // ---------------- eps * y ----------------
   logic               fe_v;
   logic [Y_W+E_W-1:0] fe_prod;
   logic [$bits(dv_side_type)-1:0] fe_side_vec;

   lj_mul #(.AW(Y_W), .BW(E_W), .SW($bits(dv_side_type))) u_mul_efrc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dy_v),
      .in_a     (dy_y),
      .in_b     (well_depth_ff),
      .in_side  (dy_side_vec),
      .out_valid(fe_v),
      .out_prod (fe_prod),
      .out_side (fe_side_vec)
   );

   assign dv_side_o = fe_side_vec;

   // Force magnitude: 48*eps*y / 2^22, clamp, then merge special cases.
   logic [Y_W+E_W+5:0] frc_x48;
   logic [Y_W+E_W-17:0] frc_mag;
   logic [RES_W-1:0]   frc_lim;
   logic               frc_sat;
   logic [RES_W-1:0]   frc_val;
   logic               eps_nz;
   res_type            fin_in, fin_ff;
   logic               fin_v_ff;

   assign frc_x48 = ({6'b0, fe_prod} << 5) + ({6'b0, fe_prod} << 4);
   assign frc_mag = frc_x48[Y_W+E_W+5:22];
   assign eps_nz  = well_depth_ff != '0;
   assign frc_lim = dv_side_o.neg_frc ? NEG_MAX : POS_MAX;
   assign frc_sat = (dv_side_o.big && eps_nz) || (frc_mag > {30'b0, frc_lim});
   assign frc_val = frc_sat ? frc_lim
                  : (dv_side_o.neg_frc ? -frc_mag[RES_W-1:0] : frc_mag[RES_W-1:0]);

   always_comb begin
      fin_in.inside_cutoff = dv_side_o.tag.in_cut;
      case (dv_side_o.tag.kind)
         KIND_NORMAL: begin
            fin_in.force_scalar   = dv_side_o.tag.in_cut ? frc_val : '0;
            fin_in.pair_potential = dv_side_o.pot;
            fin_in.saturated      = dv_side_o.pot_sat | (dv_side_o.tag.in_cut & frc_sat);
         end
         KIND_ZERO: begin
            fin_in.force_scalar   = dv_side_o.tag.in_cut ? NEG_MAX : '0;
            fin_in.pair_potential = NEG_MAX;
            fin_in.saturated      = 1'b1;
         end
         KIND_CLOSE: begin
            // z beyond range: true values lie far below, unless eps is zero
            fin_in.force_scalar   = eps_nz ? NEG_MAX : '0;
            fin_in.pair_potential = eps_nz ? NEG_MAX : '0;
            fin_in.saturated      = eps_nz;
         end
         default: begin
            fin_in.force_scalar   = '0;
            fin_in.pair_potential = '0;
            fin_in.saturated      = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= fe_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // ---------------- output register + skid ----------------
   logic    out_v_ff, out_v_in, skid_v_in, take;
   res_type out_ff, out_in, skid_ff, skid_in;

   assign take = out_v_ff & rsp.ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // pipe frozen; drain skid into the output register
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (fin_v_ff) begin
         if (!out_v_ff || take) begin
            out_v_in = 1'b1;
            out_in   = fin_ff;
         end else begin
            skid_v_in = 1'b1;
            skid_in   = fin_ff;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid          = out_v_ff;
   assign rsp.force_scalar   = out_ff.force_scalar;
   assign rsp.pair_potential = out_ff.pair_potential;
   assign rsp.inside_cutoff  = out_ff.inside_cutoff;
   assign rsp.saturated      = out_ff.saturated;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while output register empty");

   a_force_cutoff: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.inside_cutoff) |-> (rsp.force_scalar == '0))
      else $error("nonzero force outside cutoff");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !req.ready |=> $stable(fin_v_ff))
      else $error("pipe advanced during stall");
`endif

endmodule
